/* hw/rtl/pow2_bucket_slot_allocator_unit_defines.svh */
// Assertion macros used by the allocator control module.
`ifndef POW2_BUCKET_SLOT_ALLOCATOR_UNIT_DEFINES_SVH
`define POW2_BUCKET_SLOT_ALLOCATOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define PBSA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pbsa: same-cycle check failed");
`define PBSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pbsa: next-cycle check failed");
`else
`define PBSA_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define PBSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* hw/rtl/pbsa_pkg.sv */
package pbsa_pkg;

    localparam int COUNT_W  = 6;
    localparam int OFF_W    = 12;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 7;
    localparam int LOG_W    = 3;

    localparam logic [CFG_W-1:0] LIMIT_RESET = 7'd64;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_SIZE   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_BLOCK   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_STACK_FULL = 2'd3;

    typedef struct packed {
        logic load;
        logic exec;
    } t_pbsa_cmd;

    // Smallest b with 2^b >= n, for a request count.
    function automatic logic [LOG_W-1:0] ceil_log2(input logic [COUNT_W-1:0] n);
        logic [LOG_W-1:0] b;
        priority if (n <= 6'd1) b = 3'd0;
        else if (n <= 6'd2)     b = 3'd1;
        else if (n <= 6'd4)     b = 3'd2;
        else if (n <= 6'd8)     b = 3'd3;
        else if (n <= 6'd16)    b = 3'd4;
        else if (n <= 6'd32)    b = 3'd5;
        else                    b = 3'd6;
        return b;
    endfunction

endpackage

/* hw/rtl/pbsa_ctrl.sv */
`include "pow2_bucket_slot_allocator_unit_defines.svh"

module pbsa_ctrl
    import pbsa_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    output t_pbsa_cmd o_cmd,
    output logic      o_busy,
    output logic      o_strobe
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       load;

    assign o_busy   = (r_state == S_EXEC);
    assign o_strobe = (r_state == S_DONE);
    assign load     = i_start && !o_busy;

    assign o_cmd.load = load;
    assign o_cmd.exec = o_busy;

    always_comb begin
        unique case (r_state)
            S_IDLE:  n_state = load ? S_EXEC : S_IDLE;
            S_EXEC:  n_state = S_DONE;
            S_DONE:  n_state = load ? S_EXEC : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `PBSA_ASSERT_NEXT(a_accept_goes_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy)
    `PBSA_ASSERT_NEXT(a_busy_then_result, i_clk, i_rst_n, o_busy, o_strobe && !o_busy)
    `PBSA_ASSERT_NEXT(a_single_strobe, i_clk, i_rst_n, o_strobe, !o_strobe)
    `PBSA_ASSERT_NOW(a_strobe_not_busy, i_clk, i_rst_n, o_strobe, !o_busy && !o_cmd.exec)

endmodule

/* hw/rtl/pbsa_datapath.sv */
module pbsa_datapath
    import pbsa_pkg::*;
#(
    parameter int BLOCK_SLOTS = 64,
    parameter int MAX_BLOCKS  = 64,
    parameter int BUCKETS     = 7,
    parameter int FREE_DEPTH  = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_pbsa_cmd           i_cmd,
    input  logic                i_action,
    input  logic [COUNT_W-1:0]  i_count,
    input  logic [OFF_W-1:0]    i_offset,
    input  logic                i_cfg_we,
    input  logic [CFG_W-1:0]    i_cfg_data,
    output logic [OFF_W-1:0]    o_slot_base,
    output logic [STATUS_W-1:0] o_status
);

    localparam int BKT_W       = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int NFB_W       = $clog2(MAX_BLOCKS + 1);
    localparam int BB_W        = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int SUM_W       = $clog2(BLOCK_SLOTS + 129);
    localparam int FCNT_W      = $clog2(FREE_DEPTH + 1);
    localparam int IDX_W       = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;
    localparam int STACK_DEPTH = BUCKETS * FREE_DEPTH;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int PROD_W      = BB_W + $clog2(BLOCK_SLOTS + 1);

    localparam logic [ADDR_W-1:0] DEPTH_A   = ADDR_W'(FREE_DEPTH);
    localparam logic [FCNT_W-1:0] DEPTH_C   = FCNT_W'(FREE_DEPTH);
    localparam logic [SUM_W-1:0]  SLOTS_S   = SUM_W'(BLOCK_SLOTS);
    localparam logic [PROD_W-1:0] SLOTS_P   = PROD_W'(BLOCK_SLOTS);

    // Latched request.
    logic                r_action;
    logic [COUNT_W-1:0]  r_count;
    logic [OFF_W-1:0]    r_offset;

    logic [CFG_W-1:0]    r_block_limit;
    logic [NFB_W-1:0]    r_next_fresh;
    logic [BB_W-1:0]     r_bkt_block [BUCKETS];
    logic                r_bkt_valid [BUCKETS];
    logic [SUM_W-1:0]    r_bkt_fill  [BUCKETS];
    logic [FCNT_W-1:0]   r_free_cnt  [BUCKETS];

    logic [OFF_W-1:0]    r_stack [STACK_DEPTH];
    logic [OFF_W-1:0]    r_stack_q;

    logic [OFF_W-1:0]    r_res_offset;
    logic [STATUS_W-1:0] r_status;
    logic                r_use_mem;

    logic [LOG_W-1:0]    blog;
    logic                bad_size;
    logic [BKT_W-1:0]    bi;
    logic [FCNT_W-1:0]   fc;
    logic [SUM_W-1:0]    piece;
    logic                have_block;
    logic                fresh_ok;
    logic [BB_W-1:0]     carve_blk;
    logic [SUM_W-1:0]    carve_fill;
    logic [PROD_W-1:0]   carve_base;
    logic [SUM_W-1:0]    n_fill;
    logic [IDX_W-1:0]    stk_idx;
    logic [ADDR_W-1:0]   stk_addr;

    logic                do_push;
    logic                do_pop;
    logic                do_carve;
    logic                take_fresh;
    logic [FCNT_W-1:0]   n_free_cnt;
    logic [OFF_W-1:0]    n_res_offset;
    logic [STATUS_W-1:0] n_status;

    always_comb begin
        blog     = ceil_log2(r_count);
        bad_size = (r_count == '0) || (int'(r_count) >= BLOCK_SLOTS)
                   || (int'(blog) >= BUCKETS);
        bi       = bad_size ? '0 : BKT_W'(blog);
        fc       = r_free_cnt[bi];
        piece    = SUM_W'(1) << blog;

        have_block = r_bkt_valid[bi];
        fresh_ok   = (int'(r_next_fresh) < int'(r_block_limit))
                     && (int'(r_next_fresh) < MAX_BLOCKS);
        carve_blk  = have_block ? r_bkt_block[bi] : BB_W'(r_next_fresh);
        carve_fill = have_block ? r_bkt_fill[bi] : '0;
        carve_base = PROD_W'(carve_blk) * SLOTS_P;
        n_fill     = carve_fill + piece;

        do_push      = 1'b0;
        do_pop       = 1'b0;
        do_carve     = 1'b0;
        take_fresh   = 1'b0;
        n_free_cnt   = fc;
        n_res_offset = '0;
        n_status     = ST_OK;

        priority if (r_action == ACT_FREE && r_count == '0) begin
            n_status = ST_OK;
        end else if (bad_size) begin
            n_status = ST_BAD_SIZE;
        end else if (r_action == ACT_FREE) begin
            if (fc >= DEPTH_C) begin
                n_status = ST_STACK_FULL;
            end else begin
                do_push    = 1'b1;
                n_free_cnt = fc + FCNT_W'(1);
            end
        end else if (fc != '0) begin
            do_pop     = 1'b1;
            n_free_cnt = fc - FCNT_W'(1);
        end else if (!have_block && !fresh_ok) begin
            n_status = ST_NO_BLOCK;
        end else begin
            do_carve     = 1'b1;
            take_fresh   = !have_block;
            n_res_offset = OFF_W'(carve_base + PROD_W'(carve_fill));
        end

        // Push writes at the current top; pop reads one below it.
        stk_idx  = do_push ? IDX_W'(fc) : IDX_W'(fc - FCNT_W'(1));
        stk_addr = ADDR_W'(bi) * DEPTH_A + ADDR_W'(stk_idx);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_count  <= i_count;
            r_offset <= i_offset;
        end
        if (i_cmd.exec) begin
            r_res_offset <= n_res_offset;
            r_status     <= n_status;
            r_use_mem    <= do_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && do_push) begin
            r_stack[stk_addr] <= r_offset;
        end
        if (i_cmd.exec && do_pop) begin
            r_stack_q <= r_stack[stk_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && do_carve) begin
            r_bkt_block[bi] <= carve_blk;
            r_bkt_fill[bi]  <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_limit <= LIMIT_RESET;
            r_next_fresh  <= '0;
            for (int k = 0; k < BUCKETS; k++) begin
                r_bkt_valid[k] <= 1'b0;
                r_free_cnt[k]  <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_block_limit <= i_cfg_data;
            end
            if (i_cmd.exec) begin
                r_free_cnt[bi] <= n_free_cnt;
                if (do_carve) begin
                    // The block is dropped once the next piece would not fit.
                    r_bkt_valid[bi] <= !((n_fill + piece) > SLOTS_S);
                end
                if (take_fresh) begin
                    r_next_fresh <= r_next_fresh + NFB_W'(1);
                end
            end
        end
    end

    assign o_slot_base = r_use_mem ? r_stack_q : r_res_offset;
    assign o_status    = r_status;

endmodule

/* hw/rtl/pow2_bucket_slot_allocator_unit.sv */
// Power-of-two slot allocator: an allocate request of n slots is served from
// bucket ceil(log2 n), first from that bucket's free stack, else by carving the
// next piece from the bucket's current block, taking a fresh block when needed.
// A request is taken when start is high and busy is low. It passes through an
// execute state for the bucket state update and the free-stack memory access,
// then a result state that shows the result with o_strobe; a new start is
// taken during that result state. The receiver cannot stall: the result is
// valid only while o_strobe is high. Free-stack entries need no clearing after
// reset, so the block is ready as soon as reset is released. The block-limit
// register accepts a write in every cycle and should be written only while
// no request is in flight.
module pow2_bucket_slot_allocator_unit
    import pbsa_pkg::*;
#(
    parameter int BLOCK_SLOTS = 64,
    parameter int MAX_BLOCKS  = 64,
    parameter int BUCKETS     = 7,
    parameter int FREE_DEPTH  = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_action,
    input  logic [COUNT_W-1:0]  i_count,
    input  logic [OFF_W-1:0]    i_offset,
    output logic                o_strobe,
    output logic [OFF_W-1:0]    o_slot_base,
    output logic [STATUS_W-1:0] o_status,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CFG_W-1:0]    i_cfg_data
);

    t_pbsa_cmd cmd;

    assign o_cfg_ready = 1'b1;

    pbsa_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_strobe (o_strobe)
    );

    pbsa_datapath #(
        .BLOCK_SLOTS (BLOCK_SLOTS),
        .MAX_BLOCKS  (MAX_BLOCKS),
        .BUCKETS     (BUCKETS),
        .FREE_DEPTH  (FREE_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_action    (i_action),
        .i_count     (i_count),
        .i_offset    (i_offset),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_slot_base (o_slot_base),
        .o_status    (o_status)
    );

endmodule

/* tb/sv/slot_alloc_checker.sv */
`timescale 1ns / 1ps

module slot_alloc_checker
    import pbsa_pkg::*;
#(
    parameter int BLOCK_SLOTS = 64,
    parameter int MAX_BLOCKS  = 64,
    parameter int BUCKETS     = 7,
    parameter int FREE_DEPTH  = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_busy,
    input  logic                i_action,
    input  logic [COUNT_W-1:0]  i_count,
    input  logic [OFF_W-1:0]    i_offset,
    input  logic                i_strobe,
    input  logic [OFF_W-1:0]    i_slot_base,
    input  logic [STATUS_W-1:0] i_status,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic [CFG_W-1:0]    i_cfg_data,
    output int                  o_pending,
    output int                  o_fail_count,
    output int                  o_result_count,
    output int                  o_refusal_count
);

    typedef struct packed {
        logic [OFF_W-1:0]    slot_base;
        logic [STATUS_W-1:0] status;
    } grant_t;

    grant_t expected_grants[$];

    // Shadow copy of the allocator state.
    logic [CFG_W-1:0] block_limit;
    int               next_block;
    int               cur_block  [BUCKETS];
    logic             cur_valid  [BUCKETS];
    int               cur_fill   [BUCKETS];
    logic [OFF_W-1:0] free_offsets [BUCKETS][FREE_DEPTH];
    int               free_depth [BUCKETS];
    int               fail_count;
    int               result_count;
    int               refusal_count;

    function automatic int bucket_of(input logic [COUNT_W-1:0] n);
        int b;
        b = 0;
        while ((1 << b) < int'(n))
            b++;
        return b;
    endfunction

    task automatic predict_grant(input logic act, input logic [COUNT_W-1:0] cnt,
                                 input logic [OFF_W-1:0] off, output grant_t g);
        int b;
        int piece;
        int lim;
        g.slot_base = '0;
        g.status    = ST_OK;
        b = bucket_of(cnt);
        if (act == ACT_FREE && cnt == '0) begin
            // A free of no slots is dropped without a trace.
        end else if (cnt == '0 || int'(cnt) >= BLOCK_SLOTS || b >= BUCKETS) begin
            g.status = ST_BAD_SIZE;
        end else if (act == ACT_FREE) begin
            if (free_depth[b] >= FREE_DEPTH) begin
                g.status = ST_STACK_FULL;
            end else begin
                free_offsets[b][free_depth[b]] = off;
                free_depth[b]++;
            end
        end else if (free_depth[b] > 0) begin
            free_depth[b]--;
            g.slot_base = free_offsets[b][free_depth[b]];
        end else begin
            piece = 1 << b;
            lim = (int'(block_limit) < MAX_BLOCKS) ? int'(block_limit) : MAX_BLOCKS;
            if (!cur_valid[b] && next_block < lim) begin
                cur_block[b] = next_block;
                cur_valid[b] = 1'b1;
                cur_fill[b]  = 0;
                next_block++;
            end
            if (!cur_valid[b]) begin
                g.status = ST_NO_BLOCK;
            end else begin
                g.slot_base = OFF_W'(cur_block[b] * BLOCK_SLOTS + cur_fill[b]);
                cur_fill[b] += piece;
                // The block is given up once the next piece would not fit.
                if (cur_fill[b] + piece > BLOCK_SLOTS)
                    cur_valid[b] = 1'b0;
            end
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        if (fail_count < 40)
            $display("[%0t] mismatch: %s got %0d expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    always @(posedge i_clk) begin : watch
        grant_t want;
        grant_t fresh;
        int     i;
        if (!i_rst_n) begin
            block_limit = LIMIT_RESET;
            next_block  = 0;
            for (i = 0; i < BUCKETS; i++) begin
                cur_block[i]  = 0;
                cur_valid[i]  = 1'b0;
                cur_fill[i]   = 0;
                free_depth[i] = 0;
            end
            expected_grants.delete();
            fail_count    = 0;
            result_count  = 0;
            refusal_count = 0;
        end else begin
            // The result of an older request is retired before a new transfer
            // taken at the same edge is predicted.
            if (i_strobe) begin
                result_count++;
                if (i_status != ST_OK)
                    refusal_count++;
                if (expected_grants.size() == 0) begin
                    report_mismatch("result with no request pending, slot_base",
                                    int'(i_slot_base), 0);
                end else begin
                    want = expected_grants.pop_front();
                    if (i_slot_base != want.slot_base)
                        report_mismatch("slot_base", int'(i_slot_base),
                                        int'(want.slot_base));
                    if (i_status != want.status)
                        report_mismatch("status", int'(i_status), int'(want.status));
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                block_limit = i_cfg_data;
            if (i_start && !i_busy) begin
                predict_grant(i_action, i_count, i_offset, fresh);
                expected_grants.push_back(fresh);
            end
        end
        o_pending       <= expected_grants.size();
        o_fail_count    <= fail_count;
        o_result_count  <= result_count;
        o_refusal_count <= refusal_count;
    end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top
    import pbsa_pkg::*;
;

    localparam int RUN_LIMIT    = 500000;
    localparam int RANDOM_ITEMS = 2000;
    localparam int PHASES       = 7;
    localparam int TOP_BUCKET   = 6;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                start       = 1'b0;
    logic                busy;
    logic                i_action    = ACT_ALLOC;
    logic [COUNT_W-1:0]  i_count     = '0;
    logic [OFF_W-1:0]    i_offset    = '0;
    logic                o_strobe;
    logic [OFF_W-1:0]    o_slot_base;
    logic [STATUS_W-1:0] o_status;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [CFG_W-1:0]    i_cfg_data  = '0;

    int pending;
    int fail_count;
    int result_count;
    int refusal_count;
    int cycle_count    = 0;
    int requests_sent  = 0;
    int limit_writes   = 0;

    int phase_limit    [PHASES] = '{0, 1, 3, 16, 0, 64, 127};
    int phase_free_pct [PHASES] = '{50, 30, 70, 75, 50, 40, 20};

    pow2_bucket_slot_allocator_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_action    (i_action),
        .i_count     (i_count),
        .i_offset    (i_offset),
        .o_strobe    (o_strobe),
        .o_slot_base (o_slot_base),
        .o_status    (o_status),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    slot_alloc_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_action        (i_action),
        .i_count         (i_count),
        .i_offset        (i_offset),
        .i_strobe        (o_strobe),
        .i_slot_base     (o_slot_base),
        .i_status        (o_status),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_pending       (pending),
        .o_fail_count    (fail_count),
        .o_result_count  (result_count),
        .o_refusal_count (refusal_count)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("run limit of %0d cycles reached", RUN_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    // Start stays high from here until a gap lowers it, so back-to-back
    // requests never see it dropped and raised in one step.
    task automatic send_request(input logic act, input logic [COUNT_W-1:0] cnt,
                                input logic [OFF_W-1:0] off);
        start    <= 1'b1;
        i_action <= act;
        i_count  <= cnt;
        i_offset <= off;
        do @(posedge i_clk); while (busy);
        requests_sent++;
    endtask

    task automatic idle_for(input int cycles);
        if (cycles > 0) begin
            start <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    function automatic int pick_gap(input int mode);
        int r;
        if (mode == 0)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic drain;
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_block_limit(input logic [CFG_W-1:0] value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        limit_writes++;
    endtask

    task automatic run_random_phase(input int n_items, input int free_pct);
        int               focus;
        int               gap_mode;
        int               b;
        int               r;
        int               i;
        logic             act;
        logic [COUNT_W-1:0] cnt;
        focus    = $urandom_range(0, TOP_BUCKET);
        gap_mode = $urandom_range(0, 3);
        for (i = 0; i < n_items; i++) begin
            // Hammering one bucket for a while fills its free stack or drains it.
            if (i % 64 == 63) begin
                focus    = $urandom_range(0, TOP_BUCKET);
                gap_mode = $urandom_range(0, 3);
            end
            act = ($urandom_range(0, 99) < free_pct) ? ACT_FREE : ACT_ALLOC;
            r = $urandom_range(0, 99);
            if (r < 8) begin
                cnt = COUNT_W'($urandom_range(0, 63));
            end else begin
                b = (r < 75) ? focus : $urandom_range(0, TOP_BUCKET);
                if (b == 0)
                    cnt = COUNT_W'(1);
                else
                    cnt = COUNT_W'($urandom_range((1 << (b - 1)) + 1,
                                   (b == TOP_BUCKET) ? 63 : (1 << b)));
            end
            send_request(act, cnt, OFF_W'($urandom_range(0, 4095)));
            idle_for(pick_gap(gap_mode));
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed opening at the reset block limit.
        send_request(ACT_ALLOC, 6'd0, 12'd0);
        send_request(ACT_FREE, 6'd0, 12'hFFF);
        send_request(ACT_ALLOC, 6'd1, 12'hFFF);
        send_request(ACT_ALLOC, 6'd1, 12'd0);
        idle_for(1);
        send_request(ACT_ALLOC, 6'd2, 12'd0);
        send_request(ACT_ALLOC, 6'd63, 12'd0);
        send_request(ACT_ALLOC, 6'd33, 12'd0);
        idle_for(3);
        send_request(ACT_ALLOC, 6'd32, 12'd0);
        send_request(ACT_ALLOC, 6'd32, 12'd0);
        send_request(ACT_ALLOC, 6'd32, 12'd0);
        send_request(ACT_ALLOC, 6'd17, 12'd0);
        send_request(ACT_FREE, 6'd1, 12'hFFF);
        send_request(ACT_ALLOC, 6'd1, 12'd0);
        send_request(ACT_FREE, 6'd63, 12'd0);
        send_request(ACT_FREE, 6'd63, 12'hFFF);
        idle_for(2);
        send_request(ACT_ALLOC, 6'd40, 12'd0);
        send_request(ACT_ALLOC, 6'd40, 12'd0);
        send_request(ACT_FREE, 6'd5, 12'hAAA);
        send_request(ACT_FREE, 6'd9, 12'h555);
        send_request(ACT_ALLOC, 6'd8, 12'd0);
        send_request(ACT_ALLOC, 6'd5, 12'd0);
        send_request(ACT_ALLOC, 6'd4, 12'd0);
        send_request(ACT_ALLOC, 6'd16, 12'd0);

        phase_limit[4] = $urandom_range(1, 64);
        for (int p = 0; p < PHASES; p++) begin
            write_block_limit(CFG_W'(phase_limit[p]));
            run_random_phase(RANDOM_ITEMS / PHASES, phase_free_pct[p]);
        end

        drain();
        $display("Checked %0d results (%0d refused) from %0d requests.",
                 result_count, refusal_count, requests_sent);
        $display("Block limit was rewritten %0d times, from no blocks to past the heap size.",
                 limit_writes);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/pbsa_pkg.sv
hw/rtl/pbsa_ctrl.sv
hw/rtl/pbsa_datapath.sv
hw/rtl/pow2_bucket_slot_allocator_unit.sv
tb/sv/slot_alloc_checker.sv
tb/sv/tb_top.sv
